### hdl/srgblab_pkg.sv
// Shared types, constants and elaboration-time table functions for the sRGB to L*a*b* unit.
// Depends on nothing; top, front and back import it; srgblab_root uses FRAC_BITS_DEF.
package srgblab_pkg;

  localparam int FRAC_BITS_DEF = 20;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] light_code;
    logic [7:0] green_red_code;
    logic [7:0] blue_yellow_code;
  } lab_t;

  typedef logic [127:0] wide_t;

  // Fixed-point product, rounded half up.
  function automatic wide_t mul_f(input wide_t a, input wide_t b, input int frac);
    return (a * b + (wide_t'(1) << (frac - 1))) >> frac;
  endfunction

  // Truncated quotient of two table-building values, one bit per pass.
  function automatic wide_t div_u(input wide_t num, input wide_t den);
    wide_t q;
    wide_t r;
    int i;
    q = '0;
    r = '0;
    for (i = 127; i >= 0; i--) begin
      r = {r[126:0], num[i]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Largest s in [0, 1.0] whose fifth power does not exceed m.
  function automatic wide_t root5(input wide_t m, input int frac);
    wide_t lo;
    wide_t hi;
    wide_t mid;
    wide_t s2;
    int i;
    lo = '0;
    hi = wide_t'(1) << frac;
    for (i = 0; i < 64; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        s2 = mul_f(mid, mid, frac);
        if (mul_f(mul_f(s2, s2, frac), mid, frac) <= m) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return lo;
  endfunction

  // Inverse sRGB gamma of one byte code.
  function automatic wide_t lin_entry(input int code, input int frac);
    wide_t n;
    wide_t t;
    wide_t t2;
    if (code <= 10) begin
      return div_u((wide_t'(10 * code) << frac) + wide_t'(16473), wide_t'(32946));
    end
    n = wide_t'(1000 * code + 14025);
    t = div_u(((n << frac) * wide_t'(2)) + wide_t'(269025), wide_t'(538050));
    t2 = mul_f(t, t, frac);
    return mul_f(t2, root5(t2, frac), frac);
  endfunction

  // RGB-to-XYZ matrix in units of 1e-9.
  function automatic wide_t coef(input int row, input int col);
    case (row * 3 + col)
      0:       return wide_t'(412395589);
      1:       return wide_t'(357583431);
      2:       return wide_t'(180492647);
      3:       return wide_t'(212586231);
      4:       return wide_t'(715170304);
      5:       return wide_t'(72200499);
      6:       return wide_t'(19297215);
      7:       return wide_t'(119183865);
      default: return wide_t'(950497125);
    endcase
  endfunction

  // Matrix entry with the white point folded into its row.
  function automatic wide_t mat_entry(input int row, input int col, input int frac);
    case (row)
      0:       return div_u((coef(row, col) << frac) + wide_t'(475228000),
                            wide_t'(950456000));
      1:       return div_u((coef(row, col) << frac) + wide_t'(500000000),
                            wide_t'(1000000000));
      default: return div_u((coef(row, col) << frac) + wide_t'(544377000),
                            wide_t'(1088754000));
    endcase
  endfunction

endpackage

### hdl/srgb_to_lab_pixel_unit.sv
// Top level of the sRGB to CIE L*a*b* (D65) pixel converter.
// Depends on srgblab_pkg, srgblab_front, srgblab_queue and srgblab_back.
//
// Usage: a pixel transaction on the pix channel (pix_valid high, pix_stall low at a clock
// edge) carries one 8-bit sRGB pixel. For each one the lab channel later presents one
// transaction with L*255/100, a*+128 and b*+128, each rounded half to even and clamped to
// a byte, in the same order as the pixels came in.
// Throughput is one pixel per clock cycle while the lab side keeps taking results.
// The latency from pixel transaction to result valid is set mainly by the cube-root
// pipeline: each result bit costs one squaring stage and one cubing stage.
// The front end does the gamma lookup and feeds a four-entry queue; the back end pulls
// from that queue. When lab_stall is high while lab_valid is high, the whole back end
// holds its contents and the result stays on lab unchanged; the front keeps taking pixels
// until the queue fills, then raises pix_stall.
// Reset (rst, synchronous, active high) empties the queue and drops every valid in
// flight; no clearing pass is needed, and the block is ready in the cycle after reset.
module srgb_to_lab_pixel_unit #(
  parameter int FRAC_BITS = srgblab_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  srgblab_pkg::pix_t pix,
  output logic              lab_valid,
  input  logic              lab_stall,
  output srgblab_pkg::lab_t lab
);
  import srgblab_pkg::*;

  localparam int QW = 3 * (FRAC_BITS + 1);

  logic          front_valid;
  logic          q_full;
  logic [QW-1:0] front_data;
  logic          q_pop;
  logic          q_empty;
  logic [QW-1:0] q_data;
  logic          q_push;

  // A linearized pixel moves into the queue whenever there is room.
  assign q_push = front_valid && !q_full;

  srgblab_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .lin_valid (front_valid),
    .lin_full  (q_full),
    .lin_data  (front_data)
  );

  srgblab_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (front_data),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  srgblab_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .lin_data  (q_data),
    .lin_empty (q_empty),
    .lin_pop   (q_pop),
    .lab_valid (lab_valid),
    .lab_stall (lab_stall),
    .lab       (lab)
  );
endmodule

### hdl/srgblab_queue.sv
// Small register queue that decouples the lookup front end from the arithmetic back end.
// Depends on nothing.
module srgblab_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CNTW-1:0] count;

  assign full = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end
endmodule

### hdl/srgblab_front.sv
// Input stage: accepts a pixel and linearizes its three channels through the gamma table.
// Depends on srgblab_pkg.
module srgblab_front #(
  parameter int FRAC_BITS = srgblab_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pix_valid,
  output logic                       pix_stall,
  input  srgblab_pkg::pix_t          pix,
  output logic                       lin_valid,
  input  logic                       lin_full,
  output logic [3*(FRAC_BITS+1)-1:0] lin_data
);
  import srgblab_pkg::*;

  localparam int LW = FRAC_BITS + 1;

  logic [LW-1:0] gamma [256];

  for (genvar v = 0; v < 256; v++) begin : g_gamma
    localparam logic [LW-1:0] ENTRY = LW'(lin_entry(v, FRAC_BITS));
    assign gamma[v] = ENTRY;
  end

  assign pix_stall = lin_valid && lin_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_valid <= 1'b0;
    end else if (!pix_stall) begin
      lin_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!pix_stall) begin
      lin_data <= {gamma[pix.red], gamma[pix.green], gamma[pix.blue]};
    end
  end
endmodule

### hdl/srgblab_root.sv
// One lane of the Lab f function: bit-serial cube root pipeline beside a reciprocal divider.
// Depends on srgblab_pkg for the default fraction width.
module srgblab_root #(
  parameter int FRAC_BITS = srgblab_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS+1:0] x,
  output logic [FRAC_BITS:0]   f
);
  localparam int F = FRAC_BITS;
  localparam int XW = F + 2;
  localparam int CW = F + 1;
  localparam int NB = F + 1;
  localparam int SQW = F + 2;
  localparam int RW = F + 17;
  localparam int PW = 2 * CW + 1;
  localparam int CUW = SQW + CW + 1;
  localparam int TW = F - 2;
  localparam int QEW = F - 1;
  localparam int EFW = 2 * F - 1;
  localparam int QD = 2 * NB - 1;
  localparam logic [RW-1:0] SLOPE = RW'(24389);
  localparam logic [RW-1:0] KNEE = RW'(216) << F;
  localparam logic [RW-1:0] OFFS = (RW'(432) << F) + RW'(1566);
  localparam logic [RW-1:0] DIVISOR = RW'(3132);
  localparam logic [F:0] RECIP = (F + 1)'((longint'(4096) << F) / longint'(3132));

  // Registers at the step boundaries.
  logic [XW-1:0] x_s [NB+1];
  logic [CW-1:0] c_s [NB+1];
  logic          lin_s [NB+1];
  // Registers between the squaring half and the cubing half of a step.
  logic [XW-1:0]  x_m [NB];
  logic [CW-1:0]  c_m [NB];
  logic [CW-1:0]  cand_m [NB];
  logic [SQW-1:0] sq_m [NB];
  logic           lin_m [NB];
  // Linear segment quotient: numerator, estimate, then a delay line beside the root.
  logic [RW-1:0]  num0;
  logic [RW-1:0]  num_m;
  logic [QEW-1:0] qe_m;
  logic [CW-1:0]  q_d [QD];

  logic [RW-1:0]  scaled;
  logic [CW-1:0]  cand [NB];
  logic [PW-1:0]  sq_full [NB];
  logic [CUW-1:0] cube_full [NB];
  logic           keep [NB];
  logic [EFW-1:0] est_full;
  logic [RW-1:0]  rem_c;
  logic [CW-1:0]  q_fix;

  assign scaled = RW'(x) * SLOPE;

  // The numerator stays below 2^(F+10) on the linear segment. Its upper bits times the
  // reciprocal of 3132 give a quotient that is low by at most two, and the remainder
  // says how much to add back.
  assign est_full = EFW'(num0[12 +: TW]) * EFW'(RECIP);
  assign rem_c = num_m - RW'(qe_m) * DIVISOR;
  assign q_fix = CW'(qe_m) + CW'(rem_c >= DIVISOR) + CW'(rem_c >= (DIVISOR << 1));

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      cand[i] = c_s[i] | (CW'(1) << (NB - 1 - i));
      sq_full[i] = PW'(cand[i]) * PW'(cand[i]) + (PW'(1) << (F - 1));
      cube_full[i] = CUW'(sq_m[i]) * CUW'(cand_m[i]) + (CUW'(1) << (F - 1));
      keep[i] = cube_full[i][CUW-1:F] <= (CUW - F)'(x_m[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0] <= x;
      c_s[0] <= '0;
      lin_s[0] <= scaled < KNEE;
      num0 <= scaled + OFFS;
      num_m <= num0;
      qe_m <= est_full[F +: QEW];
      q_d[0] <= q_fix;
      for (int k = 1; k < QD; k++) begin
        q_d[k] <= q_d[k-1];
      end
      for (int i = 0; i < NB; i++) begin
        x_m[i] <= x_s[i];
        c_m[i] <= c_s[i];
        cand_m[i] <= cand[i];
        sq_m[i] <= sq_full[i][F +: SQW];
        lin_m[i] <= lin_s[i];
        x_s[i+1] <= x_m[i];
        c_s[i+1] <= keep[i] ? cand_m[i] : c_m[i];
        lin_s[i+1] <= lin_m[i];
      end
    end
  end

  assign f = lin_s[NB] ? q_d[QD-1] : c_s[NB];
endmodule

### hdl/srgblab_back.sv
// Arithmetic back end: matrix, three Lab f lanes, code rounding and the output register.
// Depends on srgblab_pkg and srgblab_root.
module srgblab_back #(
  parameter int FRAC_BITS = srgblab_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [3*(FRAC_BITS+1)-1:0] lin_data,
  input  logic                       lin_empty,
  output logic                       lin_pop,
  output logic                       lab_valid,
  input  logic                       lab_stall,
  output srgblab_pkg::lab_t          lab
);
  import srgblab_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int LW = F + 1;
  localparam int EW = F;
  localparam int XW = F + 2;
  localparam int PW = 2 * F + 2;
  localparam int LAT_ROOT = 2 * (F + 1) + 1;
  localparam int DV = 4 + LAT_ROOT;
  localparam int NLW = F + 17;
  localparam int NAW = F + 12;
  localparam int QAW = NAW - 1 - F;

  localparam logic [EW-1:0] ENT [3][3] = '{
    '{EW'(mat_entry(0, 0, F)), EW'(mat_entry(0, 1, F)), EW'(mat_entry(0, 2, F))},
    '{EW'(mat_entry(1, 0, F)), EW'(mat_entry(1, 1, F)), EW'(mat_entry(1, 2, F))},
    '{EW'(mat_entry(2, 0, F)), EW'(mat_entry(2, 1, F)), EW'(mat_entry(2, 2, F))}
  };
  localparam logic [F-1:0] HALF = F'(1) << (F - 1);

  logic en;
  logic [DV-1:0] vld;
  logic [LW-1:0] lin_r [3];
  logic [PW-1:0] prod_full [3][3];
  logic [LW-1:0] prod [3][3];
  logic [XW-1:0] xs [3];
  logic [LW-1:0] fv [3];

  logic [NLW-1:0] nl_c;
  logic [NAW-1:0] nab_c [2];
  logic [NLW-1:0] nl;
  logic [NAW-1:0] nab [2];

  logic [15:0] hi_c;
  logic [25:0] recip_c;
  logic        l_pos;
  logic [15:0] l_hi;
  logic [9:0]  l_q0;
  logic [F-1:0] l_low;
  logic [7:0]  ab_code_c [2];
  logic [7:0]  ab_code [2];

  logic [15:0] l_r0;
  logic [10:0] l_q;
  logic [7:0]  l_r;
  logic        l_up;
  logic [10:0] l_sum;
  logic [7:0]  light_c;

  assign en = !lab_valid || !lab_stall;
  assign lin_pop = en && !lin_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lab_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[DV-2:0], !lin_empty};
      lab_valid <= vld[DV-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_full[i][j] = PW'(lin_r[j]) * PW'(ENT[i][j]) + (PW'(1) << (F - 1));
        prod[i][j] = prod_full[i][j][F +: LW];
      end
    end
  end

  // Each matrix row sums to about one, so a component stays below two.
  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= lin_data[2*LW +: LW];
      lin_r[1] <= lin_data[LW +: LW];
      lin_r[2] <= lin_data[0 +: LW];
      for (int i = 0; i < 3; i++) begin
        xs[i] <= XW'(prod[i][0]) + XW'(prod[i][1]) + XW'(prod[i][2]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    srgblab_root #(.FRAC_BITS(FRAC_BITS)) u_root (
      .clk (clk),
      .en  (en),
      .x   (xs[i]),
      .f   (fv[i])
    );
  end

  always_comb begin
    nl_c = NLW'(fv[1]) * NLW'(29580) - (NLW'(4080) << F);
    nab_c[0] = NAW'(500) * (NAW'(fv[0]) - NAW'(fv[1])) + (NAW'(128) << F);
    nab_c[1] = NAW'(200) * (NAW'(fv[1]) - NAW'(fv[2])) + (NAW'(128) << F);
  end

  // The a and b codes divide by one unit, so rounding looks only at the fraction.
  always_comb begin
    logic [QAW-1:0] q;
    logic [F-1:0] low;
    logic up;
    logic [QAW:0] sum;
    for (int k = 0; k < 2; k++) begin
      q = nab[k][NAW-2:F];
      low = nab[k][F-1:0];
      up = (low > HALF) || ((low == HALF) && q[0]);
      sum = (QAW + 1)'(q) + (QAW + 1)'(up);
      if (nab[k][NAW-1] || (nab[k] == '0)) begin
        ab_code_c[k] = 8'd0;
      end else if (sum > (QAW + 1)'(255)) begin
        ab_code_c[k] = 8'd255;
      end else begin
        ab_code_c[k] = sum[7:0];
      end
    end
  end

  assign hi_c = nl[F +: 16];
  assign recip_c = 26'(hi_c) * 26'(655);

  always_ff @(posedge clk) begin
    if (en) begin
      nl <= nl_c;
      nab <= nab_c;
      l_pos <= !nl[NLW-1] && (nl != '0);
      l_hi <= hi_c;
      l_q0 <= recip_c[25:16];
      l_low <= nl[F-1:0];
      ab_code <= ab_code_c;
    end
  end

  // Light divides by 100 units: the reciprocal estimate is low by at most one.
  always_comb begin
    l_r0 = l_hi - 16'(l_q0) * 16'(100);
    if (l_r0 >= 16'(100)) begin
      l_q = 11'(l_q0) + 11'd1;
      l_r = 8'(l_r0 - 16'(100));
    end else begin
      l_q = 11'(l_q0);
      l_r = l_r0[7:0];
    end
    l_up = (l_r > 8'd50) || ((l_r == 8'd50) && ((l_low != '0) || l_q[0]));
    l_sum = l_q + 11'(l_up);
    if (!l_pos) begin
      light_c = 8'd0;
    end else if (l_sum > 11'd255) begin
      light_c = 8'd255;
    end else begin
      light_c = l_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lab.light_code <= light_c;
      lab.green_red_code <= ab_code[0];
      lab.blue_yellow_code <= ab_code[1];
    end
  end
endmodule
